@@ rtl/sim_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sim_pkg;

   // Field widths fixed by the item format
   localparam int VALUE_W     = 32;
   localparam int MATCH_IDX_W = 6;
   localparam int TOTAL_W     = 16;

   localparam logic [TOTAL_W-1:0] COUNT_MAX = {TOTAL_W{1'b1}};

   // Item actions; the unused code is dropped
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   // Control flags of a query token travelling down the chain
   typedef struct packed {
      logic valid;
      logic found;
   } tok_type;

endpackage

`default_nettype wire

@@ rtl/sim_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sim_cell
   import sim_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               wr_en,
   input  wire logic [VALUE_W-1:0] wr_data,
   input  wire logic [CNT_W-1:0]   loaded,
   input  wire tok_type            tok_i,
   input  wire logic [VALUE_W-1:0] value_i,
   input  wire logic [IDX_W-1:0]   index_i,
   output tok_type                 tok_o,
   output logic      [VALUE_W-1:0] value_o,
   output logic      [IDX_W-1:0]   index_o
);

   localparam logic [CNT_W-1:0] CELL_POS = CNT_W'(INDEX);
   localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(INDEX);

   logic [VALUE_W-1:0] entry_ff;
   tok_type            tok_ff;
   tok_type            tok_in;
   logic [VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [IDX_W-1:0]   index_in;
   logic               hit;

   // Store the entry when this slot is the next free one
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_data;
      end
   end

   // Compare only a written entry, and only if no earlier cell matched
   always_comb begin
      hit          = tok_i.valid && !tok_i.found && (CELL_POS < loaded) &&
                     (entry_ff == value_i);
      tok_in.valid = tok_i.valid;
      tok_in.found = tok_i.found || hit;
      index_in     = hit ? CELL_IDX : index_i;
   end

   // Hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_i;
         index_ff <= index_in;
      end
   end

   assign tok_o   = tok_ff;
   assign value_o = value_ff;
   assign index_o = index_ff;

endmodule

`default_nettype wire

@@ rtl/set_intersection_membership_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Set membership engine built as a chain of comparator cells.
// Request channel (req_valid / req_stall, req_action, req_value) takes clear,
// load and query items; response channel (rsp_valid / rsp_stall) returns one
// result per query: the echoed value, the hit flag, the lowest hit index and
// the saturating match count since the last clear.
// Clear and load give no response. A query walks the chain of SET_DEPTH
// cells, one cell per cycle while the chain is not held, and its response is
// registered in the output register as it leaves the chain; the next item is
// taken only after the query has left the chain.
// req_stall is high while a query is in the chain. A response waiting in the
// output register does not block clears and loads; a query reaching the end
// of the chain holds there until the output register is free.
// Synchronous reset empties the set, zeroes the count and drops any query
// and response in flight. Stored entries are not cleared.
module set_intersection_membership_top
   import sim_pkg::*;
#(
   parameter int SET_DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_action,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_query_value,
   output logic                           rsp_is_member,
   output logic [MATCH_IDX_W-1:0]         rsp_match_index,
   output logic [TOTAL_W-1:0]             rsp_match_total
);

   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CNT_W = $clog2(SET_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);

   tok_type            tok   [SET_DEPTH+1];
   logic [VALUE_W-1:0] value [SET_DEPTH+1];
   logic [IDX_W-1:0]   index [SET_DEPTH+1];
   logic [SET_DEPTH-1:0] wr_sel;

   logic [CNT_W-1:0]   loaded_ff;
   logic [TOTAL_W-1:0] count_ff;
   logic [TOTAL_W-1:0] count_in;
   logic               busy_ff;
   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_hit_ff;
   logic [MATCH_IDX_W-1:0] out_index_ff;
   logic [TOTAL_W-1:0] out_total_ff;

   logic               req_xfer;
   logic               rsp_xfer;
   logic               load_ok;
   logic               adv;
   logic               done;
   logic [IDX_W+MATCH_IDX_W-1:0] index_ext;

   action_type act;

   assign act       = action_type'(req_action);
   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !busy_ff;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign load_ok   = req_xfer && (act == ACT_LOAD) && (loaded_ff < DEPTH_CNT);

   // Hold the chain while a finished query cannot enter the output register
   assign adv  = !(tok[SET_DEPTH].valid && out_valid_ff && rsp_stall);
   assign done = tok[SET_DEPTH].valid && adv;

   // Feed a new query token into the first cell
   always_comb begin
      tok[0].valid = req_xfer && (act == ACT_QUERY);
      tok[0].found = 1'b0;
      value[0]     = req_value;
      index[0]     = '0;
   end

   // Select the slot for a load
   always_comb begin
      for (int i = 0; i < SET_DEPTH; i++) begin
         wr_sel[i] = load_ok && (loaded_ff[IDX_W-1:0] == IDX_W'(i));
      end
   end

   for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
      sim_cell #(
         .INDEX(g),
         .IDX_W(IDX_W),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .wr_en  (wr_sel[g]),
         .wr_data(req_value),
         .loaded (loaded_ff),
         .tok_i  (tok[g]),
         .value_i(value[g]),
         .index_i(index[g]),
         .tok_o  (tok[g+1]),
         .value_o(value[g+1]),
         .index_o(index[g+1])
      );
   end

   // Track fill count and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         busy_ff   <= 1'b0;
      end else begin
         if (req_xfer && (act == ACT_CLEAR)) begin
            loaded_ff <= '0;
         end else if (load_ok) begin
            loaded_ff <= loaded_ff + CNT_W'(1);
         end
         if (tok[0].valid) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Advance the saturating match count when a query leaves the chain
   always_comb begin
      count_in = count_ff;
      if (tok[SET_DEPTH].found && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + TOTAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_xfer && (act == ACT_CLEAR)) begin
         count_ff <= '0;
      end else if (done) begin
         count_ff <= count_in;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (done) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign index_ext = {{MATCH_IDX_W{1'b0}}, index[SET_DEPTH]};

   // Capture the response payload
   always_ff @(posedge clock) begin
      if (done) begin
         out_value_ff <= value[SET_DEPTH];
         out_hit_ff   <= tok[SET_DEPTH].found;
         out_index_ff <= tok[SET_DEPTH].found ? index_ext[MATCH_IDX_W-1:0] : '0;
         out_total_ff <= count_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_query_value = out_value_ff;
   assign rsp_is_member   = out_hit_ff;
   assign rsp_match_index = out_index_ff;
   assign rsp_match_total = out_total_ff;

endmodule

`default_nettype wire

@@ bench/set_intersection_membership_top_test.sv @@
`timescale 1ns / 1ps

module set_intersection_membership_top_test;
   import sim_pkg::*;

   localparam int SET_DEPTH    = 64;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DIRECTED_ROWS = 19;

   // The one action code the block has no meaning for
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_member;
      logic [MATCH_IDX_W-1:0]    index;
      logic [TOTAL_W-1:0]        total;
   } membership_answer;

   typedef struct packed {
      logic [1:0]                act;
      logic signed [VALUE_W-1:0] val;
      logic                      typed;
      membership_answer          ans;
   } stim_row;

   localparam membership_answer NO_ANSWER = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_action = ACT_CLEAR;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_query_value;
   logic                      rsp_is_member;
   logic [MATCH_IDX_W-1:0]    rsp_match_index;
   logic [TOTAL_W-1:0]        rsp_match_total;

   // Shadow copy of the reference set and counters
   logic signed [VALUE_W-1:0] set_entries [SET_DEPTH];
   int unsigned               entries_held = 0;
   logic [TOTAL_W-1:0]        hits_since_clear = '0;

   membership_answer awaited_answers [$];
   membership_answer seen_answer;
   int               mismatch_count = 0;
   int               work_done = 0;
   int               cycle_count = 0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               rsp_hold_left = 0;

   // Hand-checked opening sequence: empty set, extremes, duplicates, clear
   stim_row directed_rows [DIRECTED_ROWS] = '{
      '{ACT_QUERY,   32'sd0,           1'b1, '{32'sd0,           1'b0, 6'd0, 16'd0}},
      '{ACT_QUERY,   32'sh8000_0000,   1'b1, '{32'sh8000_0000,   1'b0, 6'd0, 16'd0}},
      '{ACT_LOAD,    32'sh7FFF_FFFF,   1'b0, NO_ANSWER},
      '{ACT_LOAD,    32'sh8000_0000,   1'b0, NO_ANSWER},
      '{ACT_LOAD,    32'sd0,           1'b0, NO_ANSWER},
      '{ACT_LOAD,    -32'sd1,          1'b0, NO_ANSWER},
      '{ACT_QUERY,   32'sh8000_0000,   1'b1, '{32'sh8000_0000,   1'b1, 6'd1, 16'd1}},
      '{ACT_QUERY,   32'sh7FFF_FFFF,   1'b1, '{32'sh7FFF_FFFF,   1'b1, 6'd0, 16'd2}},
      '{ACT_QUERY,   -32'sd1,          1'b1, '{-32'sd1,          1'b1, 6'd3, 16'd3}},
      '{ACT_QUERY,   32'sd5,           1'b1, '{32'sd5,           1'b0, 6'd0, 16'd3}},
      '{ACT_LOAD,    32'sd0,           1'b0, NO_ANSWER},
      '{ACT_QUERY,   32'sd0,           1'b1, '{32'sd0,           1'b1, 6'd2, 16'd4}},
      '{ACT_IGNORED, 32'sd0,           1'b0, NO_ANSWER},
      '{ACT_IGNORED, -32'sd1,          1'b0, NO_ANSWER},
      '{ACT_CLEAR,   32'sd0,           1'b0, NO_ANSWER},
      '{ACT_QUERY,   32'sd0,           1'b1, '{32'sd0,           1'b0, 6'd0, 16'd0}},
      '{ACT_QUERY,   -32'sd1,          1'b1, '{-32'sd1,          1'b0, 6'd0, 16'd0}},
      '{ACT_LOAD,    32'sd123,         1'b0, NO_ANSWER},
      '{ACT_QUERY,   32'sd123,         1'b1, '{32'sd123,         1'b1, 6'd0, 16'd1}}
   };

   set_intersection_membership_top #(
      .SET_DEPTH (SET_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_query_value (rsp_query_value),
      .rsp_is_member   (rsp_is_member),
      .rsp_match_index (rsp_match_index),
      .rsp_match_total (rsp_match_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Update the shadow set for one accepted item; queue the answer of a query
   function automatic void predict_membership(input logic [1:0] act,
                                              input logic signed [VALUE_W-1:0] val);
      membership_answer ans;
      bit               found;
      int               at;
      found = 1'b0;
      at = 0;
      case (act)
         ACT_CLEAR: begin
            entries_held = 0;
            hits_since_clear = '0;
         end
         ACT_LOAD: begin
            // drop loads into a full set
            if (entries_held < SET_DEPTH) begin
               set_entries[entries_held] = val;
               entries_held++;
            end
         end
         ACT_QUERY: begin
            for (int k = 0; k < entries_held; k++) begin
               if (!found && set_entries[k] == val) begin
                  found = 1'b1;
                  at = k;
               end
            end
            if (found && hits_since_clear != COUNT_MAX)
               hits_since_clear++;
            ans.value = val;
            ans.is_member = found;
            ans.index = at[MATCH_IDX_W-1:0];
            ans.total = hits_since_clear;
            awaited_answers.push_back(ans);
         end
         default: ;
      endcase
   endfunction

   // Offer one item from a falling edge; return on the falling edge after the transfer
   task automatic send_item(input logic [1:0] act, input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid  <= 1'b0;
         req_action <= 2'($urandom);
         req_value  <= $urandom;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (req_stall);
      predict_membership(act, val);
      work_done++;
      @(negedge clock);
   endtask

   // Hold the sender until every awaited answer has come back
   task automatic drain_answers();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_answers.size() != 0)
         @(negedge clock);
   endtask

   // Receiver: long hold-off on request, otherwise random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Compare each response transfer with the oldest awaited answer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("unexpected response value", rsp_query_value, 32'd0);
         end else begin
            seen_answer = awaited_answers.pop_front();
            if (rsp_query_value !== seen_answer.value)
               report_mismatch("query_value", rsp_query_value, seen_answer.value);
            if (rsp_is_member !== seen_answer.is_member)
               report_mismatch("is_member", 32'(rsp_is_member),
                               32'(seen_answer.is_member));
            if (rsp_match_index !== seen_answer.index)
               report_mismatch("match_index", 32'(rsp_match_index),
                               32'(seen_answer.index));
            if (rsp_match_total !== seen_answer.total)
               report_mismatch("match_total", 32'(rsp_match_total),
                               32'(seen_answer.total));
         end
      end
   end

   initial begin : stimulus
      logic signed [VALUE_W-1:0] val;
      int                        pick;
      int                        n_loads;
      int                        n_queries;
      int                        target;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_item(directed_rows[r].act, directed_rows[r].val);
         if (directed_rows[r].typed)
            awaited_answers[awaited_answers.size() - 1] = directed_rows[r].ans;
      end

      // Random sequences in three stall mixes
      work_done = 0;
      for (int phase = 0; phase < 3; phase++) begin
         drain_answers();
         case (phase)
            0: begin req_idle_pct = 7;  rsp_idle_pct = 64; end
            1: begin req_idle_pct = 64; rsp_idle_pct = 7;  end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         // fill the block while the receiver holds off
         rsp_hold_left = HOLD_CYCLES;
         target = (phase + 1) * RANDOM_ITEMS / 3;
         while (work_done < target) begin
            pick = $urandom_range(99);
            if (pick < 10)
               send_item(ACT_CLEAR, $urandom);
            n_loads = (pick < 5) ? $urandom_range(60, 70) : $urandom_range(0, 10);
            for (int i = 0; i < n_loads; i++) begin
               pick = $urandom_range(99);
               if (pick < 30)
                  val = $signed($urandom_range(0, 15)) - 8;
               else if (pick < 35)
                  val = (pick[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
               else
                  val = $urandom;
               send_item(ACT_LOAD, val);
            end
            n_queries = $urandom_range(1, 6);
            for (int i = 0; i < n_queries; i++) begin
               pick = $urandom_range(99);
               if (entries_held > 0 && pick < 60)
                  val = set_entries[$urandom_range(0, entries_held - 1)];
               else if (pick < 80)
                  val = $signed($urandom_range(0, 15)) - 8;
               else if (pick < 85)
                  val = (pick[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
               else
                  val = $urandom;
               send_item(ACT_QUERY, val);
            end
            if ($urandom_range(99) < 5)
               send_item(ACT_IGNORED, $urandom);
         end
      end

      // Wind down and let any stray response show up
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (SET_DEPTH + 10) @(posedge clock);
      if (awaited_answers.size() != 0)
         report_mismatch("answers left over", awaited_answers.size(), 32'd0);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
